### rtl/planar_odometry_integrator_top_assert.svh
// Assertion macros shared by the odometry integrator RTL.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_TOP_ASSERT_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define POI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define POI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/poi_pkg.sv
// Shared types, widths and the arctangent table of the odometry integrator.
package poi_pkg;

    // Field and datapath widths
    localparam int ANGLE_W      = 32;
    localparam int TRIG_W       = 32;
    localparam int ZACC_W       = 33;
    localparam int VEL_W        = 20;
    localparam int YAW_W        = 24;
    localparam int DT_W         = 20;
    localparam int POS_W        = 32;
    localparam int WVEL_W       = 38;
    localparam int MUL_A_W      = 38;
    localparam int MUL_B_W      = 21;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int ATAN_ENTRIES = 24;
    localparam int STEP_W       = 5;

    // Reciprocal of the limit CORDIC gain, Q30
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    // Request and status between the sequencer and the CORDIC unit
    typedef struct packed {
        logic               start;
        logic [ANGLE_W-1:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_sts_t;

    // Arctangent of 2^-i as a binary angle (2^31 = pi)
    function automatic logic [ANGLE_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
        logic [ANGLE_W-1:0] v;
        unique case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/planar_odometry_integrator_top.sv
// Top level of the planar dead-reckoning odometry integrator.
// Each transfer on the slave side carries a body velocity, a yaw rate and a time step; the block
// rotates the velocity by the heading held before the update (sine and cosine from an iterative
// CORDIC, one micro-rotation per cycle), integrates x, y and heading, and sends one pose transfer
// on the master side. x and y saturate at the 32-bit limits, heading is a binary angle that wraps.
// The pose resets to zero. An item passes through an accept state, the CORDIC micro-rotations,
// the seven products and a flush through the single shared multiplier, and the load of the
// output register, which waits while the previous pose still waits there. s_tready is high
// only while the block is idle; a finished pose may wait in the output register while the
// next item is taken.
module planar_odometry_integrator_top
    import poi_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vel_forward[19:0], vel_side[39:20], yaw_rate[63:40], time_step[83:64], zero pad
    input  logic [87:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pose_x[31:0], pose_y[63:32], heading[95:64]
    output logic [95:0]  m_tdata
);

    typedef enum logic [1:0] {S_IDLE, S_ROT, S_MUL, S_DONE} state_t;

    typedef enum logic [2:0] {
        OP_VF_C, OP_VS_S, OP_VF_S, OP_VS_C, OP_WX_DT, OP_WY_DT, OP_WZ_DT, OP_FLUSH
    } mul_op_t;

    localparam logic signed [PROD_W-1:0] HALF_14 = PROD_W'(1) <<< 13;
    localparam logic signed [PROD_W-1:0] HALF_36 = PROD_W'(1) <<< 35;
    localparam logic signed [PROD_W-1:0] HALF_9  = PROD_W'(1) <<< 8;
    localparam logic signed [POS_W:0]    POS_MAX = (POS_W+1)'((64'sd1 <<< (POS_W-1)) - 1);
    localparam logic signed [POS_W:0]    POS_MIN = -((POS_W+1)'(64'sd1 <<< (POS_W-1)));

    state_t                     state_reg, state_next;
    mul_op_t                    op_reg, op_next;
    logic                       m_tvalid_reg, m_tvalid_next;

    logic signed [VEL_W-1:0]    vf_reg, vf_next;
    logic signed [VEL_W-1:0]    vs_reg, vs_next;
    logic signed [YAW_W-1:0]    wz_reg, wz_next;
    logic [DT_W-1:0]            dt_reg, dt_next;
    logic signed [PROD_W-1:0]   acc_reg, acc_next;
    logic signed [WVEL_W-1:0]   wx_reg, wx_next;
    logic signed [WVEL_W-1:0]   wy_reg, wy_next;
    logic signed [POS_W-1:0]    x_reg, x_next;
    logic signed [POS_W-1:0]    y_reg, y_next;
    logic [ANGLE_W-1:0]         hd_reg, hd_next;
    logic [95:0]                out_reg, out_next;

    cordic_req_t                cordic_req;
    cordic_sts_t                cordic_sts;
    logic signed [TRIG_W-1:0]   cos_q30;
    logic signed [TRIG_W-1:0]   sin_q30;

    logic                       mul_en;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   product;

    logic                       in_xfer;
    logic signed [MUL_B_W-1:0]  dt_ext;
    logic signed [PROD_W-1:0]   vel_sum;
    logic signed [PROD_W-1:0]   disp_rnd;
    logic signed [PROD_W-1:0]   hd_rnd;
    logic signed [POS_W:0]      pos_sum;
    logic signed [POS_W:0]      pos_sat;
    logic signed [POS_W:0]      pos_old;

    assign in_xfer  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;
    assign dt_ext   = $signed({{(MUL_B_W-DT_W){1'b0}}, dt_reg});

    // Start the CORDIC on the stored heading when an item is taken
    assign cordic_req.start = in_xfer;
    assign cordic_req.angle = hd_reg;

    poi_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (cordic_req),
        .sts     (cordic_sts),
        .cos_q30 (cos_q30),
        .sin_q30 (sin_q30)
    );

    poi_mul u_mul (
        .clk     (clk),
        .en      (mul_en),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    // Select multiplier operands for the op issued this cycle
    always_comb
    begin
        mul_en = (state_reg == S_MUL);
        mul_a  = '0;
        mul_b  = '0;
        unique case (op_reg)
            OP_VF_C:
            begin
                mul_a = MUL_A_W'(cos_q30);
                mul_b = MUL_B_W'(vf_reg);
            end
            OP_VS_S:
            begin
                mul_a = MUL_A_W'(sin_q30);
                mul_b = MUL_B_W'(vs_reg);
            end
            OP_VF_S:
            begin
                mul_a = MUL_A_W'(sin_q30);
                mul_b = MUL_B_W'(vf_reg);
            end
            OP_VS_C:
            begin
                mul_a = MUL_A_W'(cos_q30);
                mul_b = MUL_B_W'(vs_reg);
            end
            OP_WX_DT:
            begin
                mul_a = wx_reg;
                mul_b = dt_ext;
            end
            OP_WY_DT:
            begin
                mul_a = wy_reg;
                mul_b = dt_ext;
            end
            OP_WZ_DT:
            begin
                mul_a = MUL_A_W'(wz_reg);
                mul_b = dt_ext;
            end
            OP_FLUSH:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Round world velocity, displacement and heading step from the registered product
    always_comb
    begin
        vel_sum  = (op_reg == OP_VF_S) ? (acc_reg - product) : (acc_reg + product);
        vel_sum  = vel_sum + HALF_14;
        disp_rnd = (product + HALF_36) >>> 36;
        hd_rnd   = (product + HALF_9) >>> 9;
        pos_old  = (op_reg == OP_WY_DT) ? (POS_W+1)'(x_reg) : (POS_W+1)'(y_reg);
        pos_sum  = pos_old + (POS_W+1)'(disp_rnd);
        if (pos_sum > POS_MAX)
        begin
            pos_sat = POS_MAX;
        end
        else if (pos_sum < POS_MIN)
        begin
            pos_sat = POS_MIN;
        end
        else
        begin
            pos_sat = pos_sum;
        end
    end

    // Sequence accept, rotation, products and output load
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        m_tvalid_next = m_tvalid_reg;
        vf_next       = vf_reg;
        vs_next       = vs_reg;
        wz_next       = wz_reg;
        dt_next       = dt_reg;
        acc_next      = acc_reg;
        wx_next       = wx_reg;
        wy_next       = wy_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        hd_next       = hd_reg;
        out_next      = out_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    vf_next    = $signed(s_tdata[19:0]);
                    vs_next    = $signed(s_tdata[39:20]);
                    wz_next    = $signed(s_tdata[63:40]);
                    dt_next    = s_tdata[83:64];
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                if (cordic_sts.done)
                begin
                    op_next    = OP_VF_C;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // Consume the product of the op issued in the previous cycle
                unique case (op_reg)
                    OP_VF_C:  acc_next = acc_reg;
                    OP_VS_S:  acc_next = product;
                    OP_VF_S:  wx_next  = vel_sum[WVEL_W+13:14];
                    OP_VS_C:  acc_next = product;
                    OP_WX_DT: wy_next  = vel_sum[WVEL_W+13:14];
                    OP_WY_DT: x_next   = pos_sat[POS_W-1:0];
                    OP_WZ_DT: y_next   = pos_sat[POS_W-1:0];
                    OP_FLUSH: hd_next  = hd_reg + hd_rnd[ANGLE_W-1:0];
                endcase
                if (op_reg == OP_FLUSH)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    op_next = mul_op_t'(op_reg + 3'd1);
                end
            end
            S_DONE:
            begin
                // Load the pose once the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    out_next      = {hd_reg, y_reg, x_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
        endcase
    end

    // Hold state, pose and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_VF_C;
            m_tvalid_reg <= 1'b0;
            x_reg        <= '0;
            y_reg        <= '0;
            hd_reg       <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            m_tvalid_reg <= m_tvalid_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            hd_reg       <= hd_next;
        end
    end

    // Hold operands, partial sums and the output word
    always_ff @(posedge clk)
    begin
        vf_reg  <= vf_next;
        vs_reg  <= vs_next;
        wz_reg  <= wz_next;
        dt_reg  <= dt_next;
        acc_reg <= acc_next;
        wx_reg  <= wx_next;
        wy_reg  <= wy_next;
        out_reg <= out_next;
    end

`include "planar_odometry_integrator_top_assert.svh"

    `POI_ASSERT_NEXT(a_accept_rotates, in_xfer, (state_reg == S_ROT) && cordic_sts.busy,
        "accepted item did not start the rotation")
    `POI_ASSERT_SAME(a_valid_from_done, $rose(m_tvalid), $past(state_reg == S_DONE),
        "pose presented without finishing the sequence")
    `POI_ASSERT_SAME(a_mul_after_rot, (state_reg == S_MUL), !cordic_sts.busy,
        "products issued while the rotation runs")

endmodule

### rtl/poi_cordic.sv
// Iterative rotation-mode CORDIC: one shift-add micro-rotation per cycle.
module poi_cordic
    import poi_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cordic_req_t               req,
    output cordic_sts_t               sts,
    output logic signed [TRIG_W-1:0]  cos_q30,
    output logic signed [TRIG_W-1:0]  sin_q30
);

    localparam int NSTEPS = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEPS - 1);

    logic                      busy_reg, busy_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      flip_reg, flip_next;
    logic signed [TRIG_W-1:0]  x_reg, x_next;
    logic signed [TRIG_W-1:0]  y_reg, y_next;
    logic signed [ZACC_W-1:0]  z_reg, z_next;

    logic [1:0]                quad;
    logic                      fold;
    logic [ANGLE_W-1:0]        folded;
    logic signed [TRIG_W-1:0]  dx;
    logic signed [TRIG_W-1:0]  dy;
    logic signed [ZACC_W-1:0]  dz;

    // Fold the angle into [-pi/2, pi/2) and run one micro-rotation per cycle
    always_comb
    begin
        quad      = req.angle[ANGLE_W-1:ANGLE_W-2];
        fold      = (quad == 2'b01) || (quad == 2'b10);
        folded    = fold ? {~req.angle[ANGLE_W-1], req.angle[ANGLE_W-2:0]} : req.angle;
        dx        = y_reg >>> step_reg;
        dy        = x_reg >>> step_reg;
        dz        = $signed({1'b0, atan_lut(step_reg)});
        busy_next = busy_reg;
        step_next = step_reg;
        flip_next = flip_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            flip_next = fold;
            x_next    = CORDIC_GAIN_Q30;
            y_next    = '0;
            z_next    = ZACC_W'($signed(folded));
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - dz;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + dz;
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Hold the rotating vector
    always_ff @(posedge clk)
    begin
        flip_reg <= flip_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    // Undo the fold by negating both results
    assign cos_q30  = flip_reg ? -x_reg : x_reg;
    assign sin_q30  = flip_reg ? -y_reg : y_reg;
    assign sts.busy = busy_reg;
    assign sts.done = busy_reg && (step_reg == LAST_STEP);

`include "planar_odometry_integrator_top_assert.svh"

    `POI_ASSERT_NEXT(a_start_busy, req.start, busy_reg, "CORDIC did not start")
    `POI_ASSERT_NEXT(a_last_step_ends, sts.done && !req.start, !busy_reg,
        "CORDIC ran past its last step")
    `POI_ASSERT_SAME(a_no_restart, req.start, !busy_reg, "CORDIC restarted while busy")

endmodule

### rtl/poi_mul.sv
// Shared signed multiplier with a registered product.
module poi_mul
    import poi_pkg::*;
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [MUL_A_W-1:0]  a,
    input  logic signed [MUL_B_W-1:0]  b,
    output logic signed [PROD_W-1:0]   product
);

    logic signed [PROD_W-1:0] prod_reg;

    // Register the product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(a) * PROD_W'(b);
        end
    end

    assign product = prod_reg;

endmodule

### tb/sv/tb_planar_odometry_integrator_top.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the planar odometry integrator top level.
module tb_planar_odometry_integrator_top;
    import poi_pkg::*;

    localparam int ROT_STEPS   = 16;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SWEEP_RUN   = 24;
    localparam int RAND_ITEMS  = 420;
    localparam int CALM_ITEMS  = 100;
    localparam int LONG_HOLD   = 300;
    localparam int REPORT_MAX  = 10;
    localparam int DRAIN_WAIT  = 64;

    typedef struct packed {
        logic [POS_W-1:0]   px;
        logic [POS_W-1:0]   py;
        logic [ANGLE_W-1:0] hd;
    } pose_t;

    // Tracks the integrated pose and holds the poses still owed by the block
    class pose_tracker;
        logic signed [POS_W-1:0] x_pos;
        logic signed [POS_W-1:0] y_pos;
        logic [ANGLE_W-1:0]      head;
        longint                  atan_bam[ATAN_ENTRIES];
        pose_t                   poses_due[$];
        int                      faults;
        int                      poses_checked;

        function new();
            atan_bam = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                         10679838, 5340245, 2670163, 1335087, 667544, 333772,
                         166886, 83443, 41722, 20861, 10430, 5215,
                         2608, 1304, 652, 326, 163, 81};
            x_pos         = '0;
            y_pos         = '0;
            head          = '0;
            faults        = 0;
            poses_checked = 0;
        endfunction

        function longint round_half_up(longint v, int sh);
            return (v + (longint'(1) << (sh - 1))) >>> sh;
        endfunction

        function logic [POS_W-1:0] clamp_pos(longint v);
            if (v > 64'sh0000_0000_7FFF_FFFF)
                return 32'h7FFF_FFFF;
            if (v < -64'sh0000_0000_8000_0000)
                return 32'h8000_0000;
            return v[31:0];
        endfunction

        // Cosine and sine of a binary angle in Q30, folded into the right half plane first
        function void heading_trig(input logic [ANGLE_W-1:0] ang, output longint c,
                                   output longint s);
            logic signed [ANGLE_W-1:0] folded;
            logic                      flip;
            longint                    xr;
            longint                    yr;
            longint                    z;
            longint                    dx;
            longint                    dy;
            int                        n;
            flip   = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
            folded = flip ? (ang ^ 32'h8000_0000) : ang;
            z      = folded;
            xr     = longint'(CORDIC_GAIN_Q30);
            yr     = 0;
            n      = (ROT_STEPS < ATAN_ENTRIES) ? ROT_STEPS : ATAN_ENTRIES;
            for (int i = 0; i < n; i++)
            begin
                dx = yr >>> i;
                dy = xr >>> i;
                if (z >= 0)
                begin
                    xr = xr - dx;
                    yr = yr + dy;
                    z  = z - atan_bam[i];
                end
                else
                begin
                    xr = xr + dx;
                    yr = yr - dy;
                    z  = z + atan_bam[i];
                end
            end
            c = flip ? -xr : xr;
            s = flip ? -yr : yr;
        endfunction

        // Advance the pose by one accepted motion transfer and queue the new pose
        function void note_motion(logic signed [VEL_W-1:0] vf, logic signed [VEL_W-1:0] vs,
                                  logic signed [YAW_W-1:0] wz, logic [DT_W-1:0] dt);
            longint c;
            longint s;
            longint wx;
            longint wy;
            longint dh;
            longint dtl;
            pose_t  p;
            heading_trig(head, c, s);
            dtl   = dt;
            wx    = round_half_up(longint'(vf) * c - longint'(vs) * s, 14);
            wy    = round_half_up(longint'(vf) * s + longint'(vs) * c, 14);
            x_pos = clamp_pos(longint'(x_pos) + round_half_up(wx * dtl, 36));
            y_pos = clamp_pos(longint'(y_pos) + round_half_up(wy * dtl, 36));
            dh    = round_half_up(longint'(wz) * dtl, 9);
            head  = head + dh[31:0];
            p.px  = x_pos;
            p.py  = y_pos;
            p.hd  = head;
            poses_due.push_back(p);
        endfunction

        // Compare one pose transfer with the oldest owed pose
        function void check_pose(logic [POS_W-1:0] ax, logic [POS_W-1:0] ay,
                                 logic [ANGLE_W-1:0] ah);
            pose_t want;
            poses_checked++;
            if (poses_due.size() == 0)
            begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("ERROR: pose with none outstanding: x=%0d y=%0d h=%h",
                             $signed(ax), $signed(ay), ah);
                return;
            end
            want = poses_due.pop_front();
            if (want.px !== ax || want.py !== ay || want.hd !== ah)
            begin
                faults++;
                if (faults <= REPORT_MAX)
                begin
                    $display("ERROR: pose %0d mismatch", poses_checked);
                    if (want.px !== ax)
                        $display("  x: exp %0d got %0d", $signed(want.px), $signed(ax));
                    if (want.py !== ay)
                        $display("  y: exp %0d got %0d", $signed(want.py), $signed(ay));
                    if (want.hd !== ah)
                        $display("  heading: exp %h got %h", want.hd, ah);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;

    pose_tracker tracker;
    bit          src_idle_en;
    bit          sink_idle_en;
    int          hold_off_cycles;
    int          sink_stall_left;
    int          items_sent;
    longint      cycle_count;

    planar_odometry_integrator_top #(
        .CORDIC_STEPS(ROT_STEPS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Drive m_tready: long hold-off first, then random stall bursts, else accept
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                m_tready <= 1'b0;
            end
            else if (sink_stall_left > 0)
            begin
                sink_stall_left--;
                m_tready <= 1'b0;
            end
            else if (sink_idle_en && $urandom_range(0, 5) == 0)
            begin
                sink_stall_left = $urandom_range(1, 5) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= rst_n;
        end
    end

    // Check every pose transfer
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_pose(m_tdata[31:0], m_tdata[63:32], m_tdata[95:64]);
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("planar_odometry_integrator_top test failed");
            $finish;
        end
    end

    // Offer one motion transfer, with an optional gap first, and hold it until taken
    task automatic send_item(input logic signed [VEL_W-1:0] vf,
                             input logic signed [VEL_W-1:0] vs,
                             input logic signed [YAW_W-1:0] wz,
                             input logic [DT_W-1:0] dt);
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, dt, wz, vs, vf};
        do @(posedge clk); while (s_tready !== 1'b1);
        tracker.note_motion(vf, vs, wz, dt);
        items_sent++;
    endtask

    // Drop s_tvalid and wait until every owed pose has arrived
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (tracker.poses_due.size() != 0);
    endtask

    function automatic logic [VEL_W-1:0] pick_speed();
        case ($urandom_range(0, 7))
            0:       return 20'h7FFFF;
            1:       return 20'h80000;
            2, 3:    return 20'($urandom_range(0, 4000) - 2000);
            default: return 20'($urandom());
        endcase
    endfunction

    function automatic logic [YAW_W-1:0] pick_yaw();
        case ($urandom_range(0, 7))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'($urandom_range(0, 1024) - 512);
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [DT_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return 20'h0;
            1:       return 20'h1;
            2:       return 20'hFFFFF;
            3, 4:    return 20'($urandom_range(0, 4095));
            default: return 20'($urandom());
        endcase
    endfunction

    initial
    begin
        tracker         = new();
        cycle_count     = 0;
        items_sent      = 0;
        hold_off_cycles = 0;
        sink_stall_left = 0;
        src_idle_en     = 1'b0;
        sink_idle_en    = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Drive both positions up at full speed, then back down well past zero
        for (int i = 0; i < SWEEP_RUN; i++)
            send_item(20'sh7FFFF, 20'sh7FFFF, 24'sd0, 20'hFFFFF);
        for (int i = 0; i < 2 * SWEEP_RUN; i++)
            send_item(20'sh80000, 20'sh80000, 24'sd0, 20'hFFFFF);

        // Zero step, heading onto pi and the quadrant edges, rounding and field extremes
        send_item(20'sd12345, -20'sd54321, 24'sh400000, 20'h00000);
        send_item(20'sd300000, -20'sd300000, 24'sh400000, 20'h40000);
        send_item(20'sd300000, 20'sd200000, 24'sd0, 20'hFFFFF);
        send_item(-20'sd1, 20'sd1, 24'sh400000, 20'h20000);
        send_item(20'sh7FFFF, 20'sh80000, 24'sd0, 20'hFFFFF);
        send_item(20'sh80000, 20'sh7FFFF, 24'sh400000, 20'h20000);
        send_item(20'sd4096, -20'sd4096, 24'sh400000, 20'h20000);
        send_item(20'sh7FFFF, 20'sh7FFFF, 24'sd0, 20'hFFFFF);
        send_item(20'sd0, 20'sd0, 24'sd256, 20'h00001);
        send_item(20'sd0, 20'sd0, -24'sd256, 20'h00001);
        send_item(20'sd0, 20'sd0, -24'sd257, 20'h00001);
        send_item(20'sh7FFFF, 20'sh80000, 24'sh7FFFFF, 20'hFFFFF);
        send_item(20'sh80000, 20'sh7FFFF, 24'sh800000, 20'hFFFFF);
        send_item(20'sh7FFFF, 20'sh7FFFF, -24'sd1, 20'h00001);
        send_item(20'sd0, 20'sd0, 24'sd0, 20'h00000);
        send_item(20'sd1, -20'sd1, 24'sd1, 20'hFFFFF);
        pause_until_drained();

        // Random motion with idling on both sides, then a calm stretch at full rate
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == 150)
                hold_off_cycles = LONG_HOLD;
            if (i == 300)
                pause_until_drained();
            if (i == RAND_ITEMS - CALM_ITEMS)
            begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end
            send_item(pick_speed(), pick_speed(), pick_yaw(), pick_step());
        end

        // Drain and report
        pause_until_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Run: %0d motion transfers, %0d poses checked, %0d faults",
                 items_sent, tracker.poses_checked, tracker.faults);
        $display("Covered: full-speed position swings, heading at pi and quadrant edges,");
        $display("  zero step, half-up rounding, random stalls and a long output hold-off");
        if (tracker.faults == 0 && tracker.poses_due.size() == 0)
            $display("planar_odometry_integrator_top test passed");
        else
            $display("planar_odometry_integrator_top test failed");
        $finish;
    end

endmodule
